FILE: src/lzw_byte_compressor_defines.svh
// Assertion macros shared by the LZW compressor RTL.
// Depends on nothing; included by the top level only.
`ifndef LZW_BYTE_COMPRESSOR_DEFINES_SVH
`define LZW_BYTE_COMPRESSOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LBC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/lbc_pkg.sv
// Types and constants of the LZW byte compressor.
// No dependencies; imported by every module of the block.
package lbc_pkg;

    localparam int DICT_CODES = 4096;
    // Slot count must be a power of two: the hash and probe index wrap by masking.
    localparam int HASH_SLOTS = 8192;

    localparam int BYTE_W = 8;
    localparam int OUT_W  = 12;
    localparam int CODE_W = $clog2(DICT_CODES);
    localparam int NF_W   = CODE_W + 1;
    localparam int KEY_W  = CODE_W + BYTE_W;
    localparam int SLOT_W = $clog2(HASH_SLOTS);
    localparam int EP_W   = 8;

    localparam int FIRST_CODE = 256;
    localparam logic [NF_W-1:0] NF_FIRST = NF_W'(FIRST_CODE);
    localparam logic [NF_W-1:0] NF_LIMIT = NF_W'(DICT_CODES);
    localparam logic [31:0]     HASH_MULT = 32'h9E37_79B1;
    localparam logic [EP_W-1:0] EP_FIRST  = EP_W'(1);
    localparam logic [EP_W-1:0] EP_CLEAR  = '0;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [OUT_W-1:0] code_word;
        logic             final_code;
    } t_out_item;

    typedef struct packed {
        logic [EP_W-1:0]   epoch;
        logic [KEY_W-1:0]  key;
        logic [CODE_W-1:0] code;
    } t_dict_entry;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_EMIT_MISS,
        S_EMIT_LAST
    } t_state;

    typedef struct packed {
        logic accept;       // take the input beat
        logic hash;         // fold hash, read home slot
        logic probe_next;   // collision: read next slot
        logic hit_load;     // prefix becomes matched code
        logic miss;         // insert pair if room
        logic emit;         // load output register with prefix
        logic emit_final;
        logic restart;      // prefix becomes the byte
        logic end_stream;   // drop prefix, new epoch
        logic clear_write;  // clearing pass write
    } t_ctrl_cmd;

    typedef struct packed {
        logic prefix_valid;
        logic in_last;      // end flag of the offered input beat
        logic last;         // end flag of the held byte
        logic hit;
        logic empty;
        logic probe_full;
        logic out_free;
        logic epoch_wrap;
        logic clr_done;
    } t_dp_status;

endpackage

FILE: src/lzw_byte_compressor.sv
// LZW byte compressor, 12-bit code words, one byte per input beat. A byte that
// starts a stream is only accepted; any other byte is accepted with the hash
// multiply, then goes through hash fold with the first dictionary read and the
// compare, plus one extra probe per collision in the linearly probed hash table,
// which has a single registered read port. Each code emitted takes an emit step,
// stalled while the output register is full. Up to two codes leave per byte; the
// last code of a stream carries final_code. Stream end retires the dictionary by
// advancing an 8-bit epoch; after reset and after every 255th stream the memory is
// swept, one slot per cycle, over all HASH_SLOTS (8192) slots; no byte is accepted meanwhile.
`include "lzw_byte_compressor_defines.svh"

module lzw_byte_compressor
    import lbc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    lbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lbc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_status    (status)
    );

    `LBC_ASSERT_IMPL(a_emit_room, i_clk, i_rst_n, cmd.emit, status.out_free, "emit into full output register")
    `LBC_ASSERT_IMPL(a_clear_blocks, i_clk, i_rst_n, cmd.clear_write, !o_in_ready, "input ready during clearing pass")
    `LBC_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && o_in_ready && status.prefix_valid, !o_in_ready, "second beat taken during lookup")

endmodule

FILE: src/lbc_ctrl.sv
// Sequencer of the LZW compressor: accept, hash, probe, emit, clear.
// Depends on lbc_pkg; drives the datapath through t_ctrl_cmd.
module lbc_ctrl
    import lbc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_write = 1'b1;
                if (i_status.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.prefix_valid) begin
                        n_state = S_HASH;
                    end else if (i_status.in_last) begin
                        n_state = S_EMIT_LAST;
                    end
                end
            end
            S_HASH: begin
                o_cmd.hash = 1'b1;
                n_state    = S_PROBE;
            end
            S_PROBE: begin
                if (i_status.hit) begin
                    o_cmd.hit_load = 1'b1;
                    n_state = i_status.last ? S_EMIT_LAST : S_IDLE;
                end else if (i_status.empty || i_status.probe_full) begin
                    o_cmd.miss = 1'b1;
                    n_state    = S_EMIT_MISS;
                end else begin
                    o_cmd.probe_next = 1'b1;
                end
            end
            S_EMIT_MISS: begin
                if (i_status.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.restart = 1'b1;
                    n_state = i_status.last ? S_EMIT_LAST : S_IDLE;
                end
            end
            S_EMIT_LAST: begin
                if (i_status.out_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.emit_final = 1'b1;
                    o_cmd.end_stream = 1'b1;
                    n_state = i_status.epoch_wrap ? S_CLEAR : S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

FILE: src/lbc_datapath.sv
// Prefix, hash, dictionary memory and output register of the compressor.
// Depends on lbc_pkg; follows commands from lbc_ctrl.
module lbc_datapath
    import lbc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_in_data,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output t_out_item  o_out_data,
    input  t_ctrl_cmd  i_cmd,
    output t_dp_status o_status
);

    t_dict_entry r_mem [HASH_SLOTS];
    t_dict_entry r_rd;

    logic [CODE_W-1:0] r_prefix;
    logic              r_prefix_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic [KEY_W-1:0]  r_key;
    logic [31:0]       r_prod;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    logic [SLOT_W-1:0] r_probes;
    logic [NF_W-1:0]   r_next_free;
    logic [EP_W-1:0]   r_epoch;
    logic [SLOT_W-1:0] r_clr;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [KEY_W-1:0]  in_key;
    logic [31:0]       fold;
    logic              rd_valid;
    logic              rd_match;
    logic              room;
    logic              out_free;

    assign in_key   = {r_prefix, i_in_data.data_byte};
    assign fold     = r_prod ^ (r_prod >> 15);
    assign rd_valid = (r_rd.epoch == r_epoch);
    assign rd_match = rd_valid && (r_rd.key == r_key);
    assign room     = (r_next_free < NF_LIMIT);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_slot = r_slot;
        if (i_cmd.hash) begin
            n_slot = fold[SLOT_W-1:0];
        end else if (i_cmd.probe_next) begin
            n_slot = r_slot + 1'b1;
        end
    end

    // Dictionary memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_write) begin
            r_mem[r_clr] <= '{epoch: EP_CLEAR, key: '0, code: '0};
        end else if (i_cmd.miss && !rd_valid && room) begin
            r_mem[r_slot] <= '{epoch: r_epoch, key: r_key,
                               code: r_next_free[CODE_W-1:0]};
        end
        r_rd <= r_mem[n_slot];
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        if (i_cmd.accept) begin
            r_byte <= i_in_data.data_byte;
            r_last <= i_in_data.end_of_stream;
            r_key  <= in_key;
            r_prod <= 32'(in_key) * HASH_MULT;
        end
        if (i_cmd.hash) begin
            r_probes <= '0;
        end else if (i_cmd.probe_next) begin
            r_probes <= r_probes + 1'b1;
        end
        if (i_cmd.accept && !r_prefix_valid) begin
            r_prefix <= CODE_W'(i_in_data.data_byte);
        end else if (i_cmd.hit_load) begin
            r_prefix <= r_rd.code;
        end else if (i_cmd.restart) begin
            r_prefix <= CODE_W'(r_byte);
        end
        if (i_cmd.emit) begin
            r_out.code_word  <= OUT_W'(r_prefix);
            r_out.final_code <= i_cmd.emit_final;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_valid <= 1'b0;
            r_next_free    <= NF_FIRST;
            r_epoch        <= EP_FIRST;
            r_clr          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.accept) begin
                r_prefix_valid <= 1'b1;
            end
            if (i_cmd.miss && !rd_valid && room) begin
                r_next_free <= r_next_free + 1'b1;
            end
            if (i_cmd.end_stream) begin
                // Bump the epoch to retire every entry; on wrap the clearing pass follows.
                r_prefix_valid <= 1'b0;
                r_next_free    <= NF_FIRST;
                r_epoch        <= (&r_epoch) ? EP_FIRST : r_epoch + 1'b1;
                r_clr          <= '0;
            end else if (i_cmd.clear_write) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        o_status              = '0;
        o_status.prefix_valid = r_prefix_valid;
        o_status.in_last      = i_in_data.end_of_stream;
        o_status.last         = r_last;
        o_status.hit          = rd_match;
        o_status.empty        = !rd_valid;
        o_status.probe_full   = rd_valid && !rd_match && (&r_probes);
        o_status.out_free     = out_free;
        o_status.epoch_wrap   = &r_epoch;
        o_status.clr_done     = &r_clr;
    end

endmodule

FILE: tb/lzw_byte_compressor_test.sv
// Self-checking testbench for the LZW byte compressor: byte streams in, 12-bit codes out.
// Depends on lbc_pkg and the lzw_byte_compressor RTL; a scoreboard class predicts the
// codes from its own dictionary and checks each output beat in order.
module lzw_byte_compressor_test
    import lbc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum {FILL_RANDOM, FILL_NARROW, FILL_RUNS} t_fill;

    class lzw_scoreboard;
        t_out_item   pending_codes[$];
        int unsigned dict_codes[int unsigned];   // {prefix, byte} -> code
        bit [15:0]   prefix_code;
        bit          prefix_valid;
        int unsigned next_code;
        int unsigned mismatches;

        function new();
            mismatches = 0;
            restart_stream();
        endfunction

        function void restart_stream();
            prefix_code  = '0;
            prefix_valid = 1'b0;
            next_code    = FIRST_CODE;
            dict_codes.delete();
        endfunction

        function void queue_code(bit [15:0] code, bit last);
            t_out_item res;
            res.code_word  = code[OUT_W-1:0];
            res.final_code = last;
            pending_codes  = {pending_codes, res};
        endfunction

        // Advance the dictionary for one accepted input beat.
        function void note_byte(t_in_item beat);
            int unsigned key;
            if (!prefix_valid) begin
                prefix_code  = 16'(beat.data_byte);
                prefix_valid = 1'b1;
            end else begin
                key = 32'({prefix_code, beat.data_byte});
                if (dict_codes.exists(key)) begin
                    prefix_code = 16'(dict_codes[key]);
                end else begin
                    queue_code(prefix_code, 1'b0);
                    // freeze once codes run out; a full hash table drops the pair
                    if (next_code < DICT_CODES && dict_codes.num() < HASH_SLOTS) begin
                        dict_codes[key] = next_code;
                        next_code++;
                    end
                    prefix_code = 16'(beat.data_byte);
                end
            end
            if (beat.end_of_stream) begin
                queue_code(prefix_code, 1'b1);
                restart_stream();
            end
        endfunction

        function void check_code(t_out_item got);
            t_out_item want;
            if (pending_codes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected code beat: code %0d final %0b",
                             got.code_word, got.final_code);
            end else begin
                want = pending_codes.pop_front();
                if (got.code_word !== want.code_word || got.final_code !== want.final_code) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("code mismatch: expected %0d final %0b, got %0d final %0b",
                                 want.code_word, want.final_code,
                                 got.code_word, got.final_code);
                end
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_data = '0;
    logic      out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    logic steady = 1'b0;      // no idling on either side
    logic sink_hold = 1'b0;   // long receiver hold-off
    int   bytes_accepted = 0;

    lzw_scoreboard sb = new();

    lzw_byte_compressor i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    always #6 i_clk = ~i_clk;

    task automatic send_byte(input logic [7:0] b, input logic eos);
        t_in_item beat;
        beat.data_byte     = b;
        beat.end_of_stream = eos;
        while (!steady && $urandom_range(99) < 24) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_byte(beat);
        bytes_accepted++;
    endtask

    task automatic send_stream(input int len, input t_fill fill);
        logic [7:0] b;
        logic [7:0] base;
        base = 8'($urandom);
        b    = base;
        for (int k = 0; k < len; k++) begin
            case (fill)
                FILL_NARROW: b = base ^ 8'($urandom_range(3));
                FILL_RUNS: if ($urandom_range(3) == 0) b = 8'($urandom);
                default: b = 8'($urandom);
            endcase
            send_byte(b, k == len - 1);
        end
    endtask

    // Receiver: check at the edge, then pick next cycle's ready.
    always @(posedge i_clk) begin
        if (o_out_valid && out_ready) sb.check_code(o_out_data);
        out_ready <= !sink_hold && (steady || $urandom_range(99) >= 24);
    end

    // Hold the output off long enough for the block to back up into its input.
    initial begin
        wait (bytes_accepted >= 700);
        @(posedge i_clk);
        sink_hold <= 1'b1;
        repeat (500) @(posedge i_clk);
        sink_hold <= 1'b0;
    end

    initial begin
        #20ms;
        $display("lzw_byte_compressor_test: done, errors");
        $finish;
    end

    initial begin
        int    len;
        int    pick;
        t_fill fill;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single-byte streams at both extremes: literal out as final
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // two bytes: miss and final together
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        // one repeated byte: prefixes grow through dictionary hits
        for (int k = 0; k < 7; k++) send_byte(8'h41, k == 6);
        for (int k = 0; k < 7; k++) send_byte(k[0] ? 8'hAA : 8'h55, k == 6);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b1);

        // many short streams, enough to wrap the dictionary epoch
        steady <= 1'b1;
        for (int s = 0; s < 280; s++) send_stream($urandom_range(3, 1), FILL_RANDOM);
        steady <= 1'b0;

        while (bytes_accepted < 1250) begin
            pick = $urandom_range(99);
            if (pick < 60)      len = $urandom_range(16, 1);
            else if (pick < 90) len = $urandom_range(64, 17);
            else                len = $urandom_range(200, 65);
            fill = t_fill'($urandom_range(2));
            send_stream(len, fill);
        end
        in_valid <= 1'b0;

        while (sb.pending_codes.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_codes.size() == 0)
            $display("lzw_byte_compressor_test: done, clean");
        else
            $display("lzw_byte_compressor_test: done, errors");
        $finish;
    end
endmodule
